FILE: rtl/core/dbks_pkg.sv
`default_nettype none

package dbks_pkg;

  // fixed field widths of the command and result transactions
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned PAY_EXT_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_FIND       = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/dbks_ram.sv
`default_nettype none

module dbks_ram #(
  parameter int unsigned WIDTH = 63,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bounded_deque_with_key_search.sv
// results: push, pop and unused codes, a push on a full queue and a pop, peek or find on an
//   empty queue give their result in the cycle after acceptance with busy low: one a cycle
// peek: the record passes the registered ram read port, then the result register; busy holds off the next
// find: the result follows the first match or the last of count records, compared by the scan
//   that reads one record per cycle through the single ram read port; busy holds off the next
// reset (rst_ni, asynchronous, active low) empties the queue; ram not cleared; no result stall
`default_nettype none

module bounded_deque_with_key_search
  import dbks_pkg::*;
#(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      res_strobe_o,
  output res_t      res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned WW = KEY_W + PAYLOAD_WIDTH;

  // one-hot sequencer: idle takes a transaction, peek waits on the ram, scan walks the ring
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PEEK = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;             // ring offset of the record now in rdata
  logic [AW-1:0] scan_addr_q, scan_addr_d; // ram address of the record now in rdata
  logic [KEY_W-1:0] key_q, key_d;          // key being searched for
  logic done_q, done_d;
  res_t res_q, res_d;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [PAY_EXT_W-1:0]     rd_pay_ext, in_pay_ext;

  logic          accept, full, empty;
  logic [AW-1:0] front_dec, head_inc, back_slot, last_slot, scan_inc;
  logic [SW-1:0] back_sum, last_sum;
  logic [CW-1:0] idx_nxt;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + AW'(1);
    end
    return r;
  endfunction

  dbks_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // record word is key over payload; the payload is kept to PAYLOAD_WIDTH bits
  assign in_pay_ext = PAY_EXT_W'(cmd_i.payload);
  assign ram_wdata  = {cmd_i.key, in_pay_ext[PAYLOAD_WIDTH-1:0]};
  assign rd_key     = ram_rdata[WW-1 -: KEY_W];
  assign rd_pay     = ram_rdata[PAYLOAD_WIDTH-1:0];
  assign rd_pay_ext = PAY_EXT_W'(rd_pay);

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);
  assign full   = (cnt_q == CW'(DEPTH));
  assign empty  = (cnt_q == '0);

  // ring arithmetic around the head
  assign front_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc  = ring_inc(head_q);
  assign scan_inc  = ring_inc(scan_addr_q);
  assign back_sum  = SW'(head_q) + SW'(cnt_q);
  assign last_sum  = back_sum - SW'(1);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  assign idx_nxt   = CW'(idx_q) + CW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    scan_addr_d = scan_addr_q;
    key_d       = key_q;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = back_slot;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    res_d       = '0;
    res_d.status = STATUS_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              done_d = 1'b1;
              if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                ram_we = 1'b1;
                if (cmd_i.operation == OP_PUSH_FRONT) begin
                  ram_waddr = front_dec;
                  head_d    = front_dec;
                end
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              done_d = 1'b1;
              if (empty) begin
                res_d.status = STATUS_NOT_FOUND;
              end else begin
                if (cmd_i.operation == OP_POP_FRONT) begin
                  head_d = head_inc;
                end
                cnt_d = cnt_q - CW'(1);
              end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = STATUS_NOT_FOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = (cmd_i.operation == OP_PEEK_FRONT) ? head_q : last_slot;
                state_d   = ST_PEEK;
              end
            end
            OP_FIND: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = STATUS_NOT_FOUND;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = head_q;
                scan_addr_d = head_q;
                idx_d       = '0;
                key_d       = cmd_i.key;
                state_d     = ST_SCAN;
              end
            end
            default: begin
              // unused code: no state change, plain ok
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_PEEK: begin
        done_d            = 1'b1;
        res_d.out_key     = rd_key;
        res_d.out_payload = rd_pay_ext[PAY_W-1:0];
        state_d           = ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_key == key_q) begin
          // first match from the front wins
          done_d            = 1'b1;
          res_d.out_key     = rd_key;
          res_d.out_payload = rd_pay_ext[PAY_W-1:0];
          res_d.position    = POS_W'(idx_nxt);
          state_d           = ST_IDLE;
        end else if (idx_nxt == cnt_q) begin
          done_d       = 1'b1;
          res_d.status = STATUS_NOT_FOUND;
          state_d      = ST_IDLE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = scan_inc;
          scan_addr_d = scan_inc;
          idx_d       = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.count = CNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // scan bookkeeping and result word carry no reset
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    scan_addr_q <= scan_addr_d;
    key_q       <= key_d;
    res_q       <= res_d;
  end

  assign res_strobe_o = done_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire
